/* hdl/edl_pkg.sv */
// Package for the definition-file lexer: mode and event codes, character constants
// and the per-byte lexing functions. No dependencies.
package edl_pkg;

	typedef enum logic [2:0] {
		M_OUT  = 3'd0,
		M_CMT  = 3'd1,
		M_HDR  = 3'd2,
		M_IN   = 3'd3,
		M_WORD = 3'd4,
		M_STR  = 3'd5,
		M_INT  = 3'd6,
		M_DEC  = 3'd7
	} mode_t;

	typedef enum logic [3:0] {
		EV_PAY   = 4'd0,
		EV_ODEF  = 4'd1,
		EV_CDEF  = 4'd2,
		EV_OPAR  = 4'd3,
		EV_CPAR  = 4'd4,
		EV_OBRC  = 4'd5,
		EV_CBRC  = 4'd6,
		EV_SEMI  = 4'd7,
		EV_QUES  = 4'd8,
		EV_NL    = 4'd9,
		EV_COMMA = 4'd10,
		EV_WORD  = 4'd11,
		EV_STR   = 4'd12,
		EV_INT   = 4'd13,
		EV_DEC   = 4'd14,
		EV_END   = 4'd15
	} event_t;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_QUES  = 8'h3F;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_LBRC  = 8'h7B;
	localparam logic [7:0] CH_RBRC  = 8'h7D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Outcome of lexing one byte in inside mode
	typedef struct packed {
		mode_t  mode;
		logic   consume;
		logic   has_ev;
		event_t ev;
	} inside_t;

	// Outcome of lexing one byte in any mode: up to two events
	typedef struct packed {
		mode_t      mode;
		logic       consume;
		logic [1:0] n;
		event_t     ev0;
		event_t     ev1;
	} lex_t;

	function automatic logic is_digit(logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// Lex one byte in inside mode; pv marks a valid lookahead byte
	function automatic inside_t lex_inside(logic [7:0] c, logic [7:0] peek, logic pv);
		inside_t r;
		r.mode    = M_IN;
		r.consume = 1'b0;
		r.has_ev  = 1'b1;
		r.ev      = EV_PAY;
		case (c) inside
			CH_STAR: begin
				r.has_ev  = pv && (peek == CH_SLASH);
				r.consume = r.has_ev;
				r.ev      = EV_CDEF;
				if (r.has_ev)
					r.mode = M_OUT;
			end
			CH_LPAR:  r.ev = EV_OPAR;
			CH_RPAR:  r.ev = EV_CPAR;
			CH_LBRC:  r.ev = EV_OBRC;
			CH_RBRC:  r.ev = EV_CBRC;
			CH_SEMI:  r.ev = EV_SEMI;
			CH_QUES:  r.ev = EV_QUES;
			CH_COMMA: r.ev = EV_COMMA;
			CH_CR: begin
				r.ev      = EV_NL;
				r.consume = pv && (peek == CH_LF);
			end
			CH_LF:    r.ev = EV_NL;
			CH_SPACE, CH_TAB: r.has_ev = 1'b0;
			CH_QUOTE: begin
				r.has_ev = 1'b0;
				r.mode   = M_STR;
			end
			default: begin
				r.mode = ((c == CH_MINUS) || is_digit(c)) ? M_INT : M_WORD;
				r.ev   = EV_PAY;
			end
		endcase
		return r;
	endfunction

	// Lex one byte in the given mode
	function automatic lex_t lex_byte(mode_t mode, logic [7:0] c, logic [7:0] peek,
			logic pv);
		lex_t    r;
		inside_t t;
		logic    word_end;
		logic    num_end;
		r.mode    = mode;
		r.consume = 1'b0;
		r.n       = 2'd0;
		r.ev0     = EV_PAY;
		r.ev1     = EV_PAY;
		t         = lex_inside(c, peek, pv);
		word_end  = (c == CH_SLASH && pv && peek == CH_STAR) || c == CH_LPAR ||
			c == CH_SPACE || c == CH_CR || c == CH_LF || c == CH_TAB;
		num_end   = c == CH_RPAR || c == CH_TAB || c == CH_COMMA || c == CH_SPACE;
		unique case (mode)
			M_OUT: begin
				if (c == CH_SLASH && pv) begin
					if (peek == CH_STAR) begin
						r.mode = M_HDR;
						r.n    = 2'd1;
						r.ev0  = EV_ODEF;
					end else if (peek == CH_SLASH) begin
						r.mode = M_CMT;
					end
				end
			end
			M_CMT: begin
				if (c == CH_LF)
					r.mode = M_OUT;
			end
			M_HDR: begin
				if (c == CH_SPACE)
					r.mode = M_IN;
			end
			M_IN: begin
				r.mode    = t.mode;
				r.consume = t.consume;
				r.n       = {1'b0, t.has_ev};
				r.ev0     = t.ev;
			end
			M_WORD: begin
				if (word_end) begin
					r.mode    = t.mode;
					r.consume = t.consume;
					r.n       = t.has_ev ? 2'd2 : 2'd1;
					r.ev0     = EV_WORD;
					r.ev1     = t.ev;
				end else begin
					r.n = 2'd1;
				end
			end
			M_STR: begin
				r.n = 2'd1;
				if (c == CH_QUOTE) begin
					r.mode = M_IN;
					r.ev0  = EV_STR;
				end
			end
			M_INT, M_DEC: begin
				if (is_digit(c) || c == CH_DOT) begin
					r.n = 2'd1;
					if (c == CH_DOT)
						r.mode = M_DEC;
				end else if (num_end) begin
					r.mode    = t.mode;
					r.consume = t.consume;
					r.n       = t.has_ev ? 2'd2 : 2'd1;
					r.ev0     = (mode == M_INT) ? EV_INT : EV_DEC;
					r.ev1     = t.ev;
				end else begin
					// keep the byte that turns the number into a word
					r.mode = M_WORD;
					r.n    = 2'd1;
				end
			end
		endcase
		return r;
	endfunction

endpackage

/* hdl/edl_if.sv */
// Handshake channels of the definition-file lexer: character input and event output.
// Depends on nothing.
interface edl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_input;

	modport source (output valid, output ch, output end_of_input, input ready);
	modport sink (input valid, input ch, input end_of_input, output ready);
endinterface

interface edl_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] event_res;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output event_res, output data_byte, output last,
		input ready);
	modport sink (input valid, input event_res, input data_byte, input last,
		output ready);
endinterface

/* hdl/entity_definition_lexer.sv */
// Lexer for a bracketed definition format, one character per beat.
// Depends on edl_pkg and on the channels in edl_if.sv.
//
// Use: characters enter on the chars channel, one per beat; a beat with
// end_of_input set closes the stream (its ch is ignored). Each character is
// held for one beat and lexed when the next one arrives, as its lookahead.
// Events leave on the tokens channel: payload characters (event 0) and
// token kinds, with last marking the final event caused by one input beat.
// An input beat causes zero to three events.
// The events of an accepted beat appear in the next cycle.
// Throughput: one input beat per cycle while tokens.ready is high, if it
// causes at most one event; a beat with more events holds the input until
// the three-entry result register drains, one event per cycle while
// tokens.ready is high. End of input returns the lexer to outside mode, nothing held.
// Reset: outside mode, nothing held, result register empty.
// Stall: while tokens.ready is low the result register holds; chars.ready
// stays high only when the result register is empty or its last event is
// being taken in that cycle.
module entity_definition_lexer
	import edl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	edl_in_if.sink           chars,
	edl_out_if.source        tokens
);

	mode_t      mode_q;
	logic [7:0] held_q;
	logic       held_valid_q;
	logic       skip_q;

	event_t     ev_s1 [3];
	logic [7:0] char_s1;
	logic [1:0] cnt_s1;
	logic [1:0] rd_q;

	lex_t       lx;
	logic       do_lex;
	logic       in_acc;
	logic       out_last;
	logic [1:0] nl;
	event_t     ev_cur;

	// Lex the held byte with the incoming one as lookahead
	always_comb begin
		lx     = lex_byte(mode_q, held_q, chars.ch, !chars.end_of_input);
		do_lex = held_valid_q && !skip_q;
		nl     = do_lex ? lx.n : 2'd0;
	end

	assign out_last     = (rd_q == (cnt_s1 - 2'd1));
	assign tokens.valid = (rd_q != cnt_s1);
	assign chars.ready  = !tokens.valid || (tokens.ready && out_last);
	assign in_acc       = chars.valid && chars.ready;

	// Advance lexer state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_OUT;
			held_q       <= 8'd0;
			held_valid_q <= 1'b0;
			skip_q       <= 1'b0;
		end else if (in_acc) begin
			if (chars.end_of_input) begin
				mode_q       <= M_OUT;
				held_q       <= 8'd0;
				held_valid_q <= 1'b0;
				skip_q       <= 1'b0;
			end else begin
				if (do_lex)
					mode_q <= lx.mode;
				skip_q       <= do_lex && lx.consume;
				held_q       <= chars.ch;
				held_valid_q <= 1'b1;
			end
		end
	end

	// Load the result register; the end event follows any lexed events
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ev_s1[0] <= (chars.end_of_input && nl == 2'd0) ? EV_END : lx.ev0;
			ev_s1[1] <= (chars.end_of_input && nl == 2'd1) ? EV_END : lx.ev1;
			ev_s1[2] <= EV_END;
			char_s1  <= held_q;
		end
	end

	// Count and read pointer of the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= 2'd0;
			rd_q   <= 2'd0;
		end else if (in_acc) begin
			cnt_s1 <= nl + {1'b0, chars.end_of_input};
			rd_q   <= 2'd0;
		end else if (tokens.valid && tokens.ready) begin
			rd_q <= rd_q + 2'd1;
		end
	end

	// Drive the event under the read pointer
	always_comb begin
		case (rd_q)
			2'd0:    ev_cur = ev_s1[0];
			2'd1:    ev_cur = ev_s1[1];
			default: ev_cur = ev_s1[2];
		endcase
	end

	assign tokens.event_res = ev_cur;
	assign tokens.data_byte = (ev_cur == EV_PAY) ? char_s1 : 8'd0;
	assign tokens.last      = out_last;

	// Input is never refused while no event waits
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!tokens.valid |-> chars.ready)
		else $error("input stalled with empty result register");

	// An end-of-input beat always yields events and clears the lexer
	a_eoi_events: assert property (@(posedge clk) disable iff (!arst_n)
		(chars.valid && chars.ready && chars.end_of_input) |=>
			(tokens.valid && !held_valid_q && mode_q == M_OUT))
		else $error("end of input not reported or state not cleared");

	// The read pointer never passes the event count
	a_rd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_q <= cnt_s1)
		else $error("read pointer beyond event count");

endmodule

/* sim/tb_entity_definition_lexer.sv */
// Testbench for entity_definition_lexer: drives character beats, predicts each event
// in SV and checks every event beat. Depends on edl_pkg and the channels in edl_if.sv.
module tb_entity_definition_lexer;
	import edl_pkg::*;

	typedef struct packed {
		event_t     ev;
		logic [7:0] data;
		logic       last;
	} lex_event_t;

	logic clk;
	logic arst_n;

	edl_in_if  chars_if();
	edl_out_if tokens_if();

	entity_definition_lexer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.tokens (tokens_if)
	);

	// Predicted lexer state
	mode_t      lex_mode;
	logic [7:0] held_byte;
	bit         held_ok;
	bit         drop_held;

	lex_event_t step_events[$];
	lex_event_t expected_events[$];

	bit quiet;
	int fails;
	int beats_sent;
	int events_checked;
	int kind_count[16];

	// Clock: period 20
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Record one event of the current beat; a beat yields at most three
	function automatic void note_event(event_t ev, logic [7:0] b);
		lex_event_t e;
		if (step_events.size() < 3) begin
			e.ev   = ev;
			e.data = (ev == EV_PAY) ? b : 8'h00;
			e.last = 1'b0;
			step_events = {step_events, e};
		end
	endfunction

	// Lex one byte inside a definition; return 1 when the lookahead is used up
	function automatic bit predict_inside(logic [7:0] c, logic [7:0] peek, bit has_peek);
		case (c)
			CH_STAR: begin
				if (has_peek && peek == CH_SLASH) begin
					lex_mode = M_OUT;
					note_event(EV_CDEF, 8'h00);
					return 1'b1;
				end
				return 1'b0;
			end
			CH_LPAR:  note_event(EV_OPAR, 8'h00);
			CH_RPAR:  note_event(EV_CPAR, 8'h00);
			CH_LBRC:  note_event(EV_OBRC, 8'h00);
			CH_RBRC:  note_event(EV_CBRC, 8'h00);
			CH_SEMI:  note_event(EV_SEMI, 8'h00);
			CH_QUES:  note_event(EV_QUES, 8'h00);
			CH_COMMA: note_event(EV_COMMA, 8'h00);
			CH_CR: begin
				note_event(EV_NL, 8'h00);
				return has_peek && peek == CH_LF;
			end
			CH_LF:    note_event(EV_NL, 8'h00);
			CH_SPACE, CH_TAB: ;
			CH_QUOTE: lex_mode = M_STR;
			default: begin
				if (c == CH_MINUS || (c >= CH_ZERO && c <= CH_NINE))
					lex_mode = M_INT;
				else
					lex_mode = M_WORD;
				note_event(EV_PAY, c);
			end
		endcase
		return 1'b0;
	endfunction

	// Lex one byte in the current mode; return 1 when the lookahead is used up
	function automatic bit predict_byte(logic [7:0] c, logic [7:0] peek, bit has_peek);
		event_t num_ev;
		case (lex_mode)
			M_OUT: begin
				if (c == CH_SLASH && has_peek) begin
					if (peek == CH_STAR) begin
						lex_mode = M_HDR;
						note_event(EV_ODEF, 8'h00);
					end else if (peek == CH_SLASH) begin
						lex_mode = M_CMT;
					end
				end
			end
			M_CMT: begin
				if (c == CH_LF)
					lex_mode = M_OUT;
			end
			M_HDR: begin
				if (c == CH_SPACE)
					lex_mode = M_IN;
			end
			M_IN: return predict_inside(c, peek, has_peek);
			M_WORD: begin
				if ((c == CH_SLASH && has_peek && peek == CH_STAR) || c == CH_LPAR ||
						c == CH_SPACE || c == CH_CR || c == CH_LF || c == CH_TAB) begin
					lex_mode = M_IN;
					note_event(EV_WORD, 8'h00);
					return predict_inside(c, peek, has_peek);
				end
				note_event(EV_PAY, c);
			end
			M_STR: begin
				if (c == CH_QUOTE) begin
					lex_mode = M_IN;
					note_event(EV_STR, 8'h00);
				end else begin
					note_event(EV_PAY, c);
				end
			end
			default: begin
				if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT) begin
					if (c == CH_DOT)
						lex_mode = M_DEC;
					note_event(EV_PAY, c);
				end else if (c == CH_RPAR || c == CH_TAB || c == CH_COMMA ||
						c == CH_SPACE) begin
					num_ev   = (lex_mode == M_INT) ? EV_INT : EV_DEC;
					lex_mode = M_IN;
					note_event(num_ev, 8'h00);
					return predict_inside(c, peek, has_peek);
				end else begin
					// keep the byte that turns the number into a word
					lex_mode = M_WORD;
					note_event(EV_PAY, c);
				end
			end
		endcase
		return 1'b0;
	endfunction

	function automatic void clear_lexer();
		lex_mode  = M_OUT;
		held_byte = 8'h00;
		held_ok   = 1'b0;
		drop_held = 1'b0;
	endfunction

	// Advance the predictor by one accepted beat and queue its events
	function automatic int predict_beat(logic [7:0] c, logic eoi);
		int n;
		step_events.delete();
		if (eoi) begin
			if (held_ok && !drop_held)
				void'(predict_byte(held_byte, 8'h00, 1'b0));
			note_event(EV_END, 8'h00);
			clear_lexer();
		end else begin
			if (held_ok && !drop_held)
				drop_held = predict_byte(held_byte, c, 1'b1);
			else
				drop_held = 1'b0;
			held_byte = c;
			held_ok   = 1'b1;
		end
		n = step_events.size();
		if (n > 0)
			step_events[n - 1].last = 1'b1;
		foreach (step_events[i])
			expected_events = {expected_events, step_events[i]};
		return n;
	endfunction

	// Send one character beat after a random gap, predict on acceptance
	task automatic send_char(logic [7:0] c, logic eoi);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 6);
		@(negedge clk);
		if (gap > 0) begin
			chars_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		chars_if.ch           = c;
		chars_if.end_of_input = eoi;
		chars_if.valid        = 1'b1;
		do
			@(posedge clk);
		while (!chars_if.ready);
		void'(predict_beat(c, eoi));
		beats_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], 1'b0);
	endtask

	// Every punctuation kind, word and number ends, number into word, CR LF,
	// stray star, string with a top-bit byte, closing pair
	task automatic test_token_kinds();
		send_text("/*h {w(1.5)7x \r\n*;?},\"");
		send_char(8'hFF, 1'b0);
		send_text("\"*/");
		send_char(8'h00, 1'b1);
	endtask

	// Zero byte in the header, then end of input on a held terminator: three events
	task automatic test_end_of_input();
		send_text("/*");
		send_char(8'h00, 1'b0);
		send_text(" a(");
		send_char(8'h00, 1'b1);
	endtask

	// Mostly well-formed definitions with random content, plus noise and cut streams
	task automatic test_random_stream();
		int ntok;
		int k;
		logic [7:0] b;
		while (beats_sent < 100) begin
			quiet = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				0: begin
					// noise bytes, any value
					repeat ($urandom_range(1, 4))
						send_char(8'($urandom_range(0, 255)), 1'b0);
				end
				1: send_char(8'($urandom_range(0, 255)), 1'b1);
				2: begin
					send_text("//");
					repeat ($urandom_range(0, 3))
						send_char(8'($urandom_range(0, 255)), 1'b0);
					send_char(CH_LF, 1'b0);
				end
				default: begin
					send_text("/*");
					repeat ($urandom_range(0, 3))
						send_char(8'("a" + $urandom_range(0, 25)), 1'b0);
					send_char(CH_SPACE, 1'b0);
					ntok = $urandom_range(2, 6);
					repeat (ntok) begin
						case ($urandom_range(0, 6))
							0: begin
								k = $urandom_range(0, 6);
								send_char(k == 0 ? CH_LPAR : k == 1 ? CH_RPAR :
									k == 2 ? CH_LBRC : k == 3 ? CH_RBRC :
									k == 4 ? CH_SEMI : k == 5 ? CH_QUES : CH_COMMA, 1'b0);
							end
							1: begin
								repeat ($urandom_range(1, 4)) begin
									b = 8'(($urandom_range(0, 7) == 0) ?
										$urandom_range(128, 255) : "a" + $urandom_range(0, 25));
									send_char(b, 1'b0);
								end
								k = $urandom_range(0, 5);
								send_char(k == 0 ? CH_LPAR : k == 1 ? CH_CR : k == 2 ? CH_LF :
									k == 3 ? CH_TAB : CH_SPACE, 1'b0);
							end
							2: begin
								if ($urandom_range(0, 2) == 0)
									send_char(CH_MINUS, 1'b0);
								repeat ($urandom_range(1, 3))
									send_char(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
								if ($urandom_range(0, 1)) begin
									send_char(CH_DOT, 1'b0);
									send_char(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
								end
								k = $urandom_range(0, 4);
								if (k == 4)
									send_char(8'("a" + $urandom_range(0, 25)), 1'b0);
								send_char(k == 0 ? CH_RPAR : k == 1 ? CH_TAB :
									k == 2 ? CH_COMMA : CH_SPACE, 1'b0);
							end
							3: begin
								send_char(CH_QUOTE, 1'b0);
								repeat ($urandom_range(0, 3)) begin
									b = 8'($urandom_range(0, 255));
									send_char(b == CH_QUOTE ? CH_DOT : b, 1'b0);
								end
								send_char(CH_QUOTE, 1'b0);
							end
							4: begin
								k = $urandom_range(0, 2);
								if (k != 1)
									send_char(CH_CR, 1'b0);
								if (k != 0)
									send_char(CH_LF, 1'b0);
							end
							5: send_text("* ");
							default: send_char(8'($urandom_range(0, 255)), 1'b0);
						endcase
					end
					// usually close, sometimes cut the stream short
					if ($urandom_range(0, 4) != 0)
						send_text("*/");
					if ($urandom_range(0, 2) == 0)
						send_char(8'($urandom_range(0, 255)), 1'b1);
				end
			endcase
		end
		quiet = 1'b0;
		send_char(8'h00, 1'b1);
	endtask

	task automatic k_stall();
		int k;
		k = quiet ? 0 : $urandom_range(0, 6);
		@(negedge clk);
		if (k > 0) begin
			tokens_if.ready = 1'b0;
			repeat (k) @(negedge clk);
		end
		tokens_if.ready = 1'b1;
		do
			@(posedge clk);
		while (!tokens_if.valid);
	endtask

	// Event sink: stall for a random gap before each beat, none while quiet
	initial begin
		tokens_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			k_stall();
		end
	end

	// Compare each event beat with the oldest prediction
	always @(posedge clk) begin : check_beat
		lex_event_t want;
		if (arst_n && tokens_if.valid && tokens_if.ready) begin
			if (expected_events.size() == 0) begin
				$error("unexpected event beat: event_res %0d data_byte %02h",
					tokens_if.event_res, tokens_if.data_byte);
				fails++;
			end else begin
				want = expected_events.pop_front();
				events_checked++;
				kind_count[want.ev]++;
				if (tokens_if.event_res !== want.ev) begin
					$error("event_res: expected %0d, got %0d", want.ev, tokens_if.event_res);
					fails++;
				end
				if (tokens_if.data_byte !== want.data) begin
					$error("data_byte: expected %02h, got %02h", want.data,
						tokens_if.data_byte);
					fails++;
				end
				if (tokens_if.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, tokens_if.last);
					fails++;
				end
			end
		end
	end

	// Hang guard
	initial begin
		#2000000;
		$display("tb_entity_definition_lexer failed");
		$finish;
	end

	initial begin
		chars_if.valid        = 1'b0;
		chars_if.ch           = 8'h00;
		chars_if.end_of_input = 1'b0;
		arst_n                = 1'b0;
		quiet                 = 1'b0;
		fails                 = 0;
		beats_sent            = 0;
		events_checked        = 0;
		clear_lexer();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_token_kinds();
		test_end_of_input();
		test_random_stream();

		// drain, then wait out any stray beats
		@(negedge clk);
		chars_if.valid = 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d character beats, checked %0d events", beats_sent, events_checked);
		$display("Token ends: word %0d, string %0d, integer %0d, decimal %0d, close %0d",
			kind_count[EV_WORD], kind_count[EV_STR], kind_count[EV_INT],
			kind_count[EV_DEC], kind_count[EV_CDEF]);
		if (fails == 0 && expected_events.size() == 0)
			$display("tb_entity_definition_lexer passed");
		else
			$display("tb_entity_definition_lexer failed");
		$finish;
	end

endmodule
